>>> sv/lst_pkg.sv
package lst_pkg;

    // width of one raw vector component and of its magnitude
    localparam int IN_W = 16;

    // three components, element 0 is x
    typedef logic [2:0][IN_W-1:0] t_vec3;

endpackage

>>> sv/lst_norm.sv
module lst_norm #(
    parameter int DOT_FRAC_BITS = 15
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  lst_pkg::t_vec3                     i_vec,
    output logic [2:0][DOT_FRAC_BITS+1:0]      o_unit,
    output logic                               o_zero
);

    localparam int F         = DOT_FRAC_BITS;
    localparam int IN_W      = lst_pkg::IN_W;
    localparam int SQ_W      = 2 * IN_W;
    localparam int ROOT_W    = IN_W;
    localparam int REM_W     = ROOT_W + 4;
    localparam int DREM_W    = ROOT_W + 1;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int QW        = F + 1;
    localparam int UW        = F + 2;
    localparam int DIV_STEPS = F + 1;

    // input and squaring stages
    lst_pkg::t_vec3          r_raw;
    lst_pkg::t_vec3          w_mag;
    lst_pkg::t_vec3          r_sqr_mag;
    logic [2:0][SQ_W-1:0]    r_sqr;
    logic [2:0]              r_sqr_neg;

    // square root steps, r_sq_n[0] holds the sum of squares
    logic [SQ_W-1:0]         r_sq_n    [0:SQ_STEPS-1];
    logic [REM_W-1:0]        r_sq_rem  [0:SQ_STEPS-2];
    logic [ROOT_W-1:0]       r_sq_root [0:SQ_STEPS-1];
    lst_pkg::t_vec3          r_sq_mag  [0:SQ_STEPS];
    logic [2:0]              r_sq_neg  [0:SQ_STEPS];

    // quotient steps
    logic [2:0][DREM_W-1:0]  r_dv_rem  [0:DIV_STEPS-2];
    logic [ROOT_W-1:0]       r_dv_len  [0:DIV_STEPS-2];
    logic [2:0][QW-1:0]      r_dv_q    [0:DIV_STEPS-1];
    logic [2:0]              r_dv_neg  [0:DIV_STEPS-1];
    logic                    r_dv_zero [0:DIV_STEPS-1];

    logic [2:0][UW-1:0]      r_unit;
    logic                    r_zero;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_mag[c] = r_raw[c][IN_W-1] ? IN_W'(~r_raw[c] + 1'b1) : r_raw[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw <= i_vec;
            for (int c = 0; c < 3; c++) begin
                r_sqr[c]     <= SQ_W'(w_mag[c]) * SQ_W'(w_mag[c]);
                r_sqr_mag[c] <= w_mag[c];
                r_sqr_neg[c] <= r_raw[c][IN_W-1];
            end
            // three squares of at most 2^30 each fit in 32 bits
            r_sq_n[0]   <= r_sqr[0] + r_sqr[1] + r_sqr[2];
            r_sq_mag[0] <= r_sqr_mag;
            r_sq_neg[0] <= r_sqr_neg;
        end
    end

    // restoring square root, one result bit per stage
    genvar j;
    for (j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [REM_W-1:0]  w_rem_sh;
        logic [REM_W-1:0]  w_trial;
        logic              w_fit;

        if (j == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_sq_rem[j-1];
            assign w_root_in = r_sq_root[j-1];
        end

        assign w_rem_sh = {w_rem_in[REM_W-3:0], r_sq_n[j][SQ_W-1 -: 2]};
        assign w_trial  = {{(REM_W-ROOT_W-2){1'b0}}, w_root_in, 2'b01};
        assign w_fit    = (w_rem_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_root[j]  <= {w_root_in[ROOT_W-2:0], w_fit};
                r_sq_mag[j+1] <= r_sq_mag[j];
                r_sq_neg[j+1] <= r_sq_neg[j];
            end
        end

        if (j < SQ_STEPS - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq_rem[j] <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
                    r_sq_n[j+1] <= r_sq_n[j] << 2;
                end
            end
        end
    end

    // long division of each magnitude by the length, one quotient bit per stage;
    // a magnitude never exceeds the length, so the quotient fits in F+1 bits
    genvar k;
    for (k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [ROOT_W-1:0]      w_len;
        logic [2:0][QW-1:0]     w_qin;
        logic [2:0][DREM_W-1:0] w_rin;
        logic [2:0]             w_neg;
        logic                   w_zero;
        logic [2:0]             w_fit;

        if (k == 0) begin : g_first
            assign w_len  = r_sq_root[SQ_STEPS-1];
            assign w_qin  = '0;
            assign w_neg  = r_sq_neg[SQ_STEPS];
            assign w_zero = (w_len == '0);
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    w_rin[c] = {1'b0, r_sq_mag[SQ_STEPS][c]};
                end
            end
        end else begin : g_next
            assign w_len  = r_dv_len[k-1];
            assign w_qin  = r_dv_q[k-1];
            assign w_neg  = r_dv_neg[k-1];
            assign w_zero = r_dv_zero[k-1];
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    w_rin[c] = {r_dv_rem[k-1][c][DREM_W-2:0], 1'b0};
                end
            end
        end

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                w_fit[c] = (w_rin[c] >= {1'b0, w_len});
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    r_dv_q[k][c] <= {w_qin[c][QW-2:0], w_fit[c]};
                end
                r_dv_neg[k]  <= w_neg;
                r_dv_zero[k] <= w_zero;
            end
        end

        if (k < DIV_STEPS - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int c = 0; c < 3; c++) begin
                        r_dv_rem[k][c] <= w_fit[c] ? (w_rin[c] - {1'b0, w_len}) : w_rin[c];
                    end
                    r_dv_len[k] <= w_len;
                end
            end
        end
    end

    // restore the sign, truncation toward zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_dv_neg[DIV_STEPS-1][c]) begin
                    r_unit[c] <= ~{1'b0, r_dv_q[DIV_STEPS-1][c]} + 1'b1;
                end else begin
                    r_unit[c] <= {1'b0, r_dv_q[DIV_STEPS-1][c]};
                end
            end
            r_zero <= r_dv_zero[DIV_STEPS-1];
        end
    end

    assign o_unit = r_unit;
    assign o_zero = r_zero;

endmodule

>>> sv/lambert_shade_texel_top.sv
// lambertian shading of one texel per item, light direction held in registers
// throughput: one item per cycle, no bubbles while the output side takes results
// each lane's normalizer has 16 square root stages and DOT_FRAC_BITS + 1 quotient stages
// reset: synchronous, active low; clears the item valid bits, the skid entry and the light
//   registers to zero; the normal-valid bits are not reset
module lambert_shade_texel_top #(
    parameter int DOT_FRAC_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_normal_x,
    input  logic [15:0] i_normal_y,
    input  logic [15:0] i_normal_z,
    input  logic        i_normal_valid,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_shade,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int F        = DOT_FRAC_BITS;
    localparam int IN_W     = lst_pkg::IN_W;
    localparam int UW       = F + 2;
    localparam int PW       = 2 * UW;
    localparam int SW       = 2 * F + 5;
    localparam int NORM_LAT = F + 21;

    localparam logic [1:0] REG_LIGHT_X = 2'd0;
    localparam logic [1:0] REG_LIGHT_Y = 2'd1;
    localparam logic [1:0] REG_LIGHT_Z = 2'd2;

    localparam logic signed [SW-1:0] DOT_ONE  = {{(SW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [UW-1:0] D_ONE    = {2'b01, {F{1'b0}}};
    localparam logic [UW-1:0]        UNIT_ONE = {2'b01, {F{1'b0}}};

    // configuration
    logic [IN_W-1:0] r_light_x;
    logic [IN_W-1:0] r_light_y;
    logic [IN_W-1:0] r_light_z;
    logic            w_cfg_wr;

    // pipeline
    logic                    w_adv;
    lst_pkg::t_vec3          w_nvec;
    lst_pkg::t_vec3          w_lvec;
    logic [2:0][UW-1:0]      w_un;
    logic [2:0][UW-1:0]      w_ul;
    logic                    w_zn;
    logic                    w_zl;

    logic [NORM_LAT-1:0]     r_vp_valid;
    logic [NORM_LAT-1:0]     r_vp_nvalid;

    logic                    r_pr_valid;
    logic                    r_pr_nvalid;
    logic                    r_pr_zero;
    logic signed [PW-1:0]    r_prod [0:2];

    logic signed [SW-1:0]    w_sum;
    logic signed [SW-1:0]    w_q;
    logic                    r_dt_valid;
    logic                    r_dt_nvalid;
    logic signed [UW-1:0]    r_dt_d;

    logic [UW-1:0]           w_t;
    logic [UW+7:0]           w_scaled;
    logic                    r_sh_valid;
    logic [7:0]              r_sh_shade;

    logic                    w_out_free;
    logic                    r_out_valid;
    logic [7:0]              r_out_shade;
    logic                    r_skid_valid;
    logic [7:0]              r_skid_shade;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_LIGHT_X: r_light_x <= pwdata[IN_W-1:0];
                REG_LIGHT_Y: r_light_y <= pwdata[IN_W-1:0];
                REG_LIGHT_Z: r_light_z <= pwdata[IN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LIGHT_X: prdata = {16'b0, r_light_x};
            REG_LIGHT_Y: prdata = {16'b0, r_light_y};
            REG_LIGHT_Z: prdata = {16'b0, r_light_z};
            default:     prdata = '0;
        endcase
    end

    // the whole pipeline moves unless the skid entry is taken
    assign w_adv   = !r_skid_valid;
    assign o_stall = r_skid_valid;

    assign w_nvec = {i_normal_z, i_normal_y, i_normal_x};
    assign w_lvec = {r_light_z, r_light_y, r_light_x};

    // the light is normalized alongside each item, so a new light applies at once
    lst_norm #(.DOT_FRAC_BITS(DOT_FRAC_BITS)) u_norm_n (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_vec  (w_nvec),
        .o_unit (w_un),
        .o_zero (w_zn)
    );

    lst_norm #(.DOT_FRAC_BITS(DOT_FRAC_BITS)) u_norm_l (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_vec  (w_lvec),
        .o_unit (w_ul),
        .o_zero (w_zl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_valid <= '0;
            r_pr_valid <= 1'b0;
            r_dt_valid <= 1'b0;
            r_sh_valid <= 1'b0;
        end else if (w_adv) begin
            r_vp_valid <= {r_vp_valid[NORM_LAT-2:0], i_valid};
            r_pr_valid <= r_vp_valid[NORM_LAT-1];
            r_dt_valid <= r_pr_valid;
            r_sh_valid <= r_dt_valid;
        end
    end

    // dot product and shade
    assign w_sum = SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2]);
    assign w_q   = w_sum >>> F;

    assign w_t      = UNIT_ONE - r_dt_d;
    assign w_scaled = {w_t, 8'b0} - {8'b0, w_t};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vp_nvalid <= {r_vp_nvalid[NORM_LAT-2:0], i_normal_valid};

            r_pr_nvalid <= r_vp_nvalid[NORM_LAT-1];
            r_pr_zero   <= w_zn || w_zl;
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= $signed(w_un[c]) * $signed(w_ul[c]);
            end

            r_dt_nvalid <= r_pr_nvalid;
            priority if (r_pr_zero) begin
                r_dt_d <= '0;
            end else if (w_q > DOT_ONE) begin
                r_dt_d <= D_ONE;
            end else if (w_q < -DOT_ONE) begin
                r_dt_d <= -D_ONE;
            end else begin
                r_dt_d <= w_q[UW-1:0];
            end

            // (1 - d) * 255 / 2 never exceeds 255 once d is clamped
            r_sh_shade <= r_dt_nvalid ? w_scaled[F+8:F+1] : 8'd0;
        end
    end

    // output register with one skid entry behind it
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_sh_valid;
            end
        end else if (!r_skid_valid && r_sh_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_shade <= r_skid_valid ? r_skid_shade : r_sh_shade;
        end else if (!r_skid_valid) begin
            r_skid_shade <= r_sh_shade;
        end
    end

    assign o_valid = r_out_valid;
    assign o_shade = r_out_shade;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register is empty");

    a_stalled_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && !r_skid_valid && r_sh_valid) |=> r_skid_valid)
        else $error("item leaving the pipeline under a stall was dropped");

    a_dot_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dt_valid |-> (r_dt_d <= D_ONE && r_dt_d >= -D_ONE))
        else $error("dot product outside the unit range");
`endif

endmodule

>>> sim/testbench.sv
module testbench;

    localparam int DOT_F = 15;
    localparam int LATENCY = DOT_F + 24;
    localparam longint UNIT = longint'(1) << DOT_F;
    localparam int PHASES = 8;
    localparam int PER_PHASE = 204;
    localparam int LONG_HOLD = 400;
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam logic [3:0] ADDR_LIGHT_X = 4'd0;
    localparam logic [3:0] ADDR_LIGHT_Y = 4'd4;
    localparam logic [3:0] ADDR_LIGHT_Z = 4'd8;
    localparam logic [3:0] ADDR_UNUSED  = 4'd12;

    localparam logic [15:0] S_MAX = 16'h7FFF;
    localparam logic [15:0] S_MIN = 16'h8000;
    localparam logic [15:0] M_ONE = 16'hFFFF;

    localparam logic [7:0] SHADE_NONE = 8'd0;
    localparam logic [7:0] SHADE_FLAT = 8'd127;
    localparam logic [7:0] SHADE_FULL = 8'd255;

    typedef longint t_vec_l [3];

    typedef struct {
        logic [15:0] lx, ly, lz;
        logic [15:0] nx, ny, nz;
        logic        nv;
        bit          known;
        logic [7:0]  shade;
    } t_texel_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_normal_x, i_normal_y, i_normal_z;
    logic        i_normal_valid;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_shade;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    logic signed [15:0] light_x, light_y, light_z;
    logic [7:0]  pending_shades [$];
    logic [7:0]  want_shade;
    int          errors = 0;
    int          stall_pct = 10;
    int          gap_pct = 10;
    bit          calm = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned cycle_count = 0;

    t_texel_row dir_rows [] = '{
        // reset light has zero length
        '{16'd0, 16'd0, 16'd0, S_MAX, S_MAX, S_MAX, 1'b1, 1'b1, SHADE_FLAT},
        '{16'd0, 16'd0, 16'd0, S_MIN, S_MIN, S_MIN, 1'b1, 1'b1, SHADE_FLAT},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, SHADE_FLAT},
        '{16'd0, 16'd0, 16'd0, 16'd1, 16'd2, 16'd3, 1'b0, 1'b1, SHADE_NONE},
        '{16'd0, 16'd0, S_MAX, 16'd0, 16'd0, S_MAX, 1'b1, 1'b1, SHADE_NONE},
        '{16'd0, 16'd0, S_MAX, 16'd0, 16'd0, S_MIN, 1'b1, 1'b1, SHADE_FULL},
        '{16'd0, 16'd0, S_MAX, S_MAX, 16'd0, 16'd0, 1'b1, 1'b1, SHADE_FLAT},
        '{16'd0, 16'd0, S_MAX, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, SHADE_FLAT},
        '{16'd0, 16'd0, S_MAX, S_MIN, S_MIN, S_MIN, 1'b0, 1'b1, SHADE_NONE},
        '{16'd0, 16'd0, S_MAX, M_ONE, M_ONE, M_ONE, 1'b1, 1'b0, SHADE_NONE},
        '{16'd0, 16'd0, S_MAX, 16'd0, S_MIN, 16'd0, 1'b1, 1'b1, SHADE_FLAT},
        '{S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, 1'b1, 1'b0, SHADE_NONE},
        '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 1'b1, 1'b0, SHADE_NONE},
        '{S_MIN, S_MIN, S_MIN, S_MAX, S_MIN, 16'h3039, 1'b1, 1'b0, SHADE_NONE},
        // rounded unit vectors push the dot past one, clamped both ways
        '{16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd0, 1'b1, 1'b1, SHADE_NONE},
        '{16'd1, 16'd1, 16'd0, M_ONE, M_ONE, 16'd0, 1'b1, 1'b1, SHADE_FULL},
        '{16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 1'b1, 1'b0, SHADE_NONE},
        '{16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, SHADE_NONE},
        '{S_MAX, S_MIN, 16'd0, S_MIN, S_MAX, 16'd0, 1'b1, 1'b0, SHADE_NONE},
        '{S_MAX, S_MIN, 16'd0, S_MAX, S_MIN, 16'd0, 1'b1, 1'b0, SHADE_NONE},
        '{S_MAX, S_MIN, 16'd0, 16'd0, 16'd0, S_MIN, 1'b1, 1'b1, SHADE_FLAT},
        '{16'd0, 16'd0, 16'd0, 16'h1234, 16'hABCD, 16'h7777, 1'b1, 1'b1, SHADE_FLAT}
    };

    lambert_shade_texel_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_normal_valid (i_normal_valid),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_shade        (o_shade),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint floor_root(input longint n);
        longint r;
        r = 0;
        for (int k = 16; k >= 0; k--) begin
            if ((r + (longint'(1) << k)) * (r + (longint'(1) << k)) <= n)
                r += longint'(1) << k;
        end
        return r;
    endfunction

    // unit vector with DOT_F fraction bits, 0 when the vector has no length
    function automatic bit unit_of(input t_vec_l v, output t_vec_l u);
        longint mag;
        mag = floor_root(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        if (mag == 0)
            return 1'b0;
        for (int k = 0; k < 3; k++)
            u[k] = (v[k] * UNIT) / mag;
        return 1'b1;
    endfunction

    function automatic logic [7:0] lambert_shade(input logic signed [15:0] nx, ny, nz,
                                                 input logic nv);
        t_vec_l nrm, lgt, un, ul;
        longint dot, lum;
        if (!nv)
            return SHADE_NONE;
        nrm = '{nx, ny, nz};
        lgt = '{light_x, light_y, light_z};
        dot = 0;
        if (unit_of(nrm, un) && unit_of(lgt, ul)) begin
            dot = (un[0] * ul[0] + un[1] * ul[1] + un[2] * ul[2]) >>> DOT_F;
            if (dot > UNIT)
                dot = UNIT;
            if (dot < -UNIT)
                dot = -UNIT;
        end
        lum = ((UNIT - dot) * 255) / (2 * UNIT);
        if (lum > 255)
            lum = 255;
        return 8'(lum);
    endfunction

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return 16'd0;
            3, 4: return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // back-to-back transfers are allowed, the caller parks the bus afterwards
    task automatic apb_xfer(input logic wr, input logic [3:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic set_light(input logic [15:0] lx, ly, lz);
        logic [31:0] back;
        logic [15:0] want_reg [3];
        logic [3:0]  addr_of [3];
        want_reg = '{lx, ly, lz};
        addr_of = '{ADDR_LIGHT_X, ADDR_LIGHT_Y, ADDR_LIGHT_Z};
        // upper bits carry junk, the block keeps only 16
        for (int k = 0; k < 3; k++)
            apb_xfer(1'b1, addr_of[k], {16'($urandom), want_reg[k]}, back);
        // nothing lives here, the write must not land anywhere
        apb_xfer(1'b1, ADDR_UNUSED, $urandom, back);
        for (int k = 0; k < 3; k++) begin
            apb_xfer(1'b0, addr_of[k], 32'd0, back);
            if (back[15:0] !== want_reg[k]) begin
                $display("%0t: light register at %0d: expected %h, got %h",
                         $time, addr_of[k], want_reg[k], back[15:0]);
                errors++;
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        light_x = lx;
        light_y = ly;
        light_z = lz;
    endtask

    task automatic send_texel(input logic [15:0] nx, ny, nz, input logic nv,
                              input logic [7:0] want);
        i_valid <= 1'b1;
        i_normal_x <= nx;
        i_normal_y <= ny;
        i_normal_z <= nz;
        i_normal_valid <= nv;
        do @(posedge i_clk); while (o_stall);
        pending_shades.push_back(want);
    endtask

    task automatic drain_shades();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_shades.size() != 0);
    endtask

    initial begin : stimulus
        logic [15:0] cx, cy, cz, lx, ly, lz;
        logic        cv;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_normal_x <= 16'd0;
        i_normal_y <= 16'd0;
        i_normal_z <= 16'd0;
        i_normal_valid <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_LIGHT_X;
        pwdata <= 32'd0;
        light_x = 16'sd0;
        light_y = 16'sd0;
        light_z = 16'sd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].lx !== light_x || dir_rows[r].ly !== light_y ||
                dir_rows[r].lz !== light_z) begin
                drain_shades();
                set_light(dir_rows[r].lx, dir_rows[r].ly, dir_rows[r].lz);
            end
            send_texel(dir_rows[r].nx, dir_rows[r].ny, dir_rows[r].nz, dir_rows[r].nv,
                       dir_rows[r].known ? dir_rows[r].shade :
                       lambert_shade(dir_rows[r].nx, dir_rows[r].ny, dir_rows[r].nz,
                                     dir_rows[r].nv));
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_shades();
            lx = (p == 1) ? S_MAX : (p == 3) ? S_MIN : pick_comp();
            ly = (p == 1) ? S_MAX : (p == 3) ? 16'd0 : pick_comp();
            lz = (p == 1) ? S_MAX : (p == 3) ? 16'd0 : pick_comp();
            set_light(lx, ly, lz);
            calm = (p == PHASES - 1);
            stall_pct = (p % 3 == 1) ? 0 : 5 + 10 * (p % 3);
            gap_pct = (p % 3 == 2) ? 0 : 5 + 10 * (p % 2);
            if (p == 2)
                long_hold_req = 1'b1;
            for (int k = 0; k < PER_PHASE; k++) begin
                if (p == 4 && k == PER_PHASE / 2)
                    drain_shades();
                if ($urandom_range(0, 31) == 0) begin
                    cx = 16'd0;
                    cy = 16'd0;
                    cz = 16'd0;
                end else begin
                    cx = pick_comp();
                    cy = pick_comp();
                    cz = pick_comp();
                end
                cv = ($urandom_range(0, 9) != 0);
                send_texel(cx, cy, cz, cv, lambert_shade(cx, cy, cz, cv));
                if (!calm && $urandom_range(0, 99) < gap_pct) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end

        drain_shades();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (errors == 0)
            $display("[lambert_shade_texel_top] OK");
        else
            $display("[lambert_shade_texel_top] ERROR");
        $finish;
    end

    initial begin : receiver
        bit held;
        held = 1'b0;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !held) begin
                // long hold so the pipe backs up into the input
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_shades.size() == 0) begin
                $display("%0t: shade %0d arrived with none expected", $time, o_shade);
                errors++;
            end else begin
                want_shade = pending_shades.pop_front();
                if (o_shade !== want_shade) begin
                    $display("%0t: shade expected %0d, got %0d", $time, want_shade, o_shade);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[lambert_shade_texel_top] ERROR");
            $finish;
        end
    end

endmodule
